// ===== rtl/weas_pkg.sv =====
// ----------------------------------------------------------------------------
// weas_pkg
// Shared constants and types of the weekly alarm schedule table.
// ----------------------------------------------------------------------------
package weas_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    localparam int IN_TDATA_W  = 96;
    localparam int IN_TUSER_W  = 3;
    localparam int OUT_TDATA_W = 32;
    localparam int OUT_TUSER_W = 2;

    // configuration port
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_TEMP_FLOOR   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TEMP_CEILING = 1'd1;
    localparam logic [7:0] TEMP_FLOOR_RST   = 8'd20;
    localparam logic [7:0] TEMP_CEILING_RST = 8'd40;

    // command opcodes
    localparam logic [2:0] OP_TICK   = 3'd0;
    localparam logic [2:0] OP_ADD    = 3'd1;
    localparam logic [2:0] OP_UPDATE = 3'd2;
    localparam logic [2:0] OP_REMOVE = 3'd3;
    localparam logic [2:0] OP_ENABLE = 3'd4;
    localparam logic [2:0] OP_CLEAR  = 3'd5;

    localparam logic [3:0] ACT_SET_TEMP = 4'd8;
    localparam logic [2:0] WDAY_NONE    = 3'd7;

    // result kinds and status codes
    localparam logic [1:0] KIND_STATUS = 2'd0;
    localparam logic [1:0] KIND_FIRED  = 2'd1;
    localparam logic [1:0] KIND_DONE   = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;

    localparam logic [15:0] ID_FIRST = 16'd1;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [15:0] entry_id;
        logic        entry_enabled;
        logic [6:0]  entry_days;
        logic [4:0]  entry_hour;
        logic [5:0]  entry_minute;
        logic [3:0]  entry_action;
        logic [7:0]  entry_value;
        logic [2:0]  now_weekday;
        logic [4:0]  now_hour;
        logic [5:0]  now_minute;
        logic [31:0] now_stamp;
    } t_cmd;

    typedef struct packed {
        logic [15:0] id;
        logic        enabled;
        logic [6:0]  days;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [3:0]  action;
        logic [7:0]  value;
    } t_entry;

    typedef struct packed {
        t_entry      ent;
        logic [31:0] stamp;
        logic        stamp_vld;
    } t_slot;

    typedef struct packed {
        logic [1:0]  kind;
        logic [1:0]  status;
        logic [15:0] id;
        logic [3:0]  action;
        logic [7:0]  value;
        logic        last;
    } t_result;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD,
        S_CHK,
        S_MV_RD,
        S_MV_WR,
        S_ADD,
        S_ACK,
        S_NF,
        S_DONE
    } t_state;

endpackage

// ===== rtl/weekly_alarm_schedule_table.sv =====
// ----------------------------------------------------------------------------
// weekly_alarm_schedule_table
// Weekly alarm table with add/update/remove/enable/clear commands and ticks.
// ----------------------------------------------------------------------------
// One transaction is taken at a time. All entries sit in a single memory with
// a registered read, so a tick reads and checks each stored entry in turn
// and then gives the done result, add and clear go straight to their status
// result, update, set-enable and remove search the entries in turn until the
// id matches, and remove then reads and writes each entry behind the removed
// one to move it up one place. Each result waits while the output register
// is still occupied.
// Results go out through an output register, so the last result of a
// transaction may still be waiting while the next transaction is taken.
// ----------------------------------------------------------------------------
module weekly_alarm_schedule_table (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // entry_id, entry_enabled, entry_days, entry_hour, entry_minute,
    // entry_action, entry_value, now_weekday, now_hour, now_minute, now_stamp
    input  logic [weas_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    // opcode
    input  logic [weas_pkg::IN_TUSER_W-1:0]  s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // status, id_out, fired_action, fired_value
    output logic [weas_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    // result_kind
    output logic [weas_pkg::OUT_TUSER_W-1:0] m_axis_tuser,
    output logic                             m_axis_tlast,
    input  logic                             i_cfg_we,
    input  logic [weas_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [weas_pkg::CFG_W-1:0]       i_cfg_data
);
    import weas_pkg::*;

    t_cmd    w_cmd;
    t_result w_eng_res, w_out_res;
    logic    w_eng_valid, w_eng_ready;

    always_comb begin
        w_cmd               = '0;
        w_cmd.opcode        = s_axis_tuser;
        w_cmd.entry_id      = s_axis_tdata[15:0];
        w_cmd.entry_enabled = s_axis_tdata[16];
        w_cmd.entry_days    = s_axis_tdata[23:17];
        w_cmd.entry_hour    = s_axis_tdata[28:24];
        w_cmd.entry_minute  = s_axis_tdata[34:29];
        w_cmd.entry_action  = s_axis_tdata[38:35];
        w_cmd.entry_value   = s_axis_tdata[46:39];
        w_cmd.now_weekday   = s_axis_tdata[49:47];
        w_cmd.now_hour      = s_axis_tdata[54:50];
        w_cmd.now_minute    = s_axis_tdata[60:55];
        w_cmd.now_stamp     = s_axis_tdata[92:61];
    end

    weas_engine u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_cmd_valid (s_axis_tvalid),
        .i_cmd       (w_cmd),
        .o_cmd_ready (s_axis_tready),
        .o_res_valid (w_eng_valid),
        .o_res       (w_eng_res),
        .i_res_ready (w_eng_ready)
    );

    weas_out u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_valid (w_eng_valid),
        .i_res       (w_eng_res),
        .o_res_ready (w_eng_ready),
        .o_valid     (m_axis_tvalid),
        .o_res       (w_out_res),
        .i_ready     (m_axis_tready)
    );

    assign m_axis_tdata = {2'b00, w_out_res.value, w_out_res.action,
                           w_out_res.id, w_out_res.status};
    assign m_axis_tuser = w_out_res.kind;
    assign m_axis_tlast = w_out_res.last;

endmodule

// ===== rtl/weas_out.sv =====
// ----------------------------------------------------------------------------
// weas_out
// Output register slice: holds one result until the master side takes it.
// ----------------------------------------------------------------------------
module weas_out (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_res_valid,
    input  weas_pkg::t_result i_res,
    output logic              o_res_ready,
    output logic              o_valid,
    output weas_pkg::t_result o_res,
    input  logic              i_ready
);
    import weas_pkg::*;

    logic    r_valid;
    t_result r_res;

    assign o_res_ready = !r_valid || i_ready;
    assign o_valid     = r_valid;
    assign o_res       = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_res_ready) begin
            r_valid <= i_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_res_ready && i_res_valid) begin
            r_res <= i_res;
        end
    end

endmodule

// ===== rtl/weas_engine.sv =====
// ----------------------------------------------------------------------------
// weas_engine
// Command sequencer around the entry memory: scan, match, fire, compact.
// ----------------------------------------------------------------------------
module weas_engine (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [weas_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [weas_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                           i_cmd_valid,
    input  weas_pkg::t_cmd                 i_cmd,
    output logic                           o_cmd_ready,
    output logic                           o_res_valid,
    output weas_pkg::t_result              o_res,
    input  logic                           i_res_ready
);
    import weas_pkg::*;

    t_state           r_state, n_state;
    t_cmd             r_cmd;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic [CNT_W-1:0] r_count, n_count;
    logic [15:0]      r_next_id, n_next_id;
    logic [7:0]       r_floor, r_ceil;

    t_slot            mem [TABLE_DEPTH];
    t_slot            r_rdata;
    logic [IDX_W-1:0] w_raddr;
    logic             w_we;
    logic [IDX_W-1:0] w_waddr;
    t_slot            w_wdata;

    logic             w_last, w_src_last, w_full, w_id_eq, w_day_hit, w_fire;
    logic [7:0]       w_lo, w_clamped;
    t_entry           w_new_ent;

    // entry at r_idx is the last one in use
    assign w_last     = (CNT_W'(r_idx) + CNT_W'(1)) == r_count;
    // source of the next move is the last entry in use
    assign w_src_last = (CNT_W'(r_idx) + CNT_W'(2)) == r_count;
    assign w_full     = r_count == CNT_W'(TABLE_DEPTH);
    assign w_id_eq    = r_rdata.ent.id == r_cmd.entry_id;

    assign w_day_hit = (r_cmd.now_weekday != WDAY_NONE) &&
                       r_rdata.ent.days[r_cmd.now_weekday];
    assign w_fire    = r_rdata.ent.enabled && w_day_hit &&
                       (r_rdata.ent.hour == r_cmd.now_hour) &&
                       (r_rdata.ent.minute == r_cmd.now_minute) &&
                       !(r_rdata.stamp_vld && (r_rdata.stamp == r_cmd.now_stamp));

    // raise to the floor first, then cap at the ceiling
    assign w_lo      = (r_rdata.ent.value < r_floor) ? r_floor : r_rdata.ent.value;
    assign w_clamped = (w_lo > r_ceil) ? r_ceil : w_lo;

    always_comb begin
        w_new_ent         = '0;
        w_new_ent.id      = r_cmd.entry_id;
        w_new_ent.enabled = r_cmd.entry_enabled;
        w_new_ent.days    = r_cmd.entry_days;
        w_new_ent.hour    = r_cmd.entry_hour;
        w_new_ent.minute  = r_cmd.entry_minute;
        w_new_ent.action  = r_cmd.entry_action;
        w_new_ent.value   = r_cmd.entry_value;
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    case (i_cmd.opcode)
                        OP_TICK:   n_state = (r_count == '0) ? S_DONE : S_RD;
                        OP_ADD:    n_state = S_ADD;
                        OP_UPDATE,
                        OP_REMOVE,
                        OP_ENABLE: n_state = (r_count == '0) ? S_NF : S_RD;
                        OP_CLEAR:  n_state = S_ACK;
                        default:   n_state = S_IDLE;
                    endcase
                end
            end
            S_RD: n_state = S_CHK;
            S_CHK: begin
                if (r_cmd.opcode == OP_TICK) begin
                    if (w_fire && !i_res_ready) begin
                        n_state = S_CHK;
                    end else begin
                        n_state = w_last ? S_DONE : S_RD;
                    end
                end else if (w_id_eq) begin
                    if (r_cmd.opcode == OP_REMOVE && !w_last) begin
                        n_state = S_MV_RD;
                    end else begin
                        n_state = S_ACK;
                    end
                end else begin
                    n_state = w_last ? S_NF : S_RD;
                end
            end
            S_MV_RD: n_state = S_MV_WR;
            S_MV_WR: n_state = w_src_last ? S_ACK : S_MV_RD;
            S_ADD, S_ACK, S_NF, S_DONE: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // outputs and datapath
    always_comb begin
        o_cmd_ready = 1'b0;
        o_res_valid = 1'b0;
        o_res       = '0;
        w_raddr     = r_idx;
        w_we        = 1'b0;
        w_waddr     = r_idx;
        w_wdata     = r_rdata;
        n_idx       = r_idx;
        n_count     = r_count;
        n_next_id   = r_next_id;
        case (r_state)
            S_IDLE: begin
                o_cmd_ready = 1'b1;
                if (i_cmd_valid) begin
                    n_idx = '0;
                    if (i_cmd.opcode == OP_CLEAR) begin
                        n_count   = '0;
                        n_next_id = ID_FIRST;
                    end
                end
            end
            S_CHK: begin
                if (r_cmd.opcode == OP_TICK) begin
                    if (w_fire) begin
                        o_res_valid   = 1'b1;
                        o_res.kind    = KIND_FIRED;
                        o_res.id      = r_rdata.ent.id;
                        o_res.action  = r_rdata.ent.action;
                        o_res.value   = (r_rdata.ent.action == ACT_SET_TEMP) ? w_clamped : 8'd0;
                        w_we              = i_res_ready;
                        w_wdata.stamp     = r_cmd.now_stamp;
                        w_wdata.stamp_vld = 1'b1;
                    end
                    if (!(w_fire && !i_res_ready) && !w_last) begin
                        n_idx = r_idx + IDX_W'(1);
                    end
                end else if (w_id_eq) begin
                    case (r_cmd.opcode)
                        OP_UPDATE: begin
                            w_we              = 1'b1;
                            w_wdata.ent       = w_new_ent;
                            w_wdata.stamp     = '0;
                            w_wdata.stamp_vld = 1'b0;
                        end
                        OP_ENABLE: begin
                            w_we                = 1'b1;
                            w_wdata.ent.enabled = r_cmd.entry_enabled;
                        end
                        OP_REMOVE: begin
                            // last entry removed: just shrink the table
                            if (w_last) begin
                                n_count = r_count - CNT_W'(1);
                            end
                        end
                        default: ;
                    endcase
                end else if (!w_last) begin
                    n_idx = r_idx + IDX_W'(1);
                end
            end
            S_MV_RD: begin
                w_raddr = r_idx + IDX_W'(1);
            end
            S_MV_WR: begin
                // move the entry behind the hole up one place
                w_we = 1'b1;
                if (w_src_last) begin
                    n_count = r_count - CNT_W'(1);
                end else begin
                    n_idx = r_idx + IDX_W'(1);
                end
            end
            S_ADD: begin
                o_res_valid = 1'b1;
                o_res.kind  = KIND_STATUS;
                o_res.last  = 1'b1;
                if (w_full) begin
                    o_res.status = ST_FULL;
                end else begin
                    o_res.status      = ST_OK;
                    o_res.id          = r_next_id;
                    w_waddr           = r_count[IDX_W-1:0];
                    w_wdata.ent       = w_new_ent;
                    w_wdata.ent.id    = r_next_id;
                    w_wdata.stamp     = '0;
                    w_wdata.stamp_vld = 1'b0;
                    if (i_res_ready) begin
                        w_we      = 1'b1;
                        n_count   = r_count + CNT_W'(1);
                        n_next_id = r_next_id + 16'd1;
                    end
                end
            end
            S_ACK: begin
                o_res_valid  = 1'b1;
                o_res.kind   = KIND_STATUS;
                o_res.status = ST_OK;
                o_res.last   = 1'b1;
            end
            S_NF: begin
                o_res_valid  = 1'b1;
                o_res.kind   = KIND_STATUS;
                o_res.status = ST_NOT_FOUND;
                o_res.last   = 1'b1;
            end
            S_DONE: begin
                o_res_valid = 1'b1;
                o_res.kind  = KIND_DONE;
                o_res.last  = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_idx     <= '0;
            r_count   <= '0;
            r_next_id <= ID_FIRST;
            r_floor   <= TEMP_FLOOR_RST;
            r_ceil    <= TEMP_CEILING_RST;
        end else begin
            r_state   <= n_state;
            r_idx     <= n_idx;
            r_count   <= n_count;
            r_next_id <= n_next_id;
            if (i_cfg_we && i_cfg_idx == CFG_TEMP_FLOOR) begin
                r_floor <= i_cfg_data;
            end
            if (i_cfg_we && i_cfg_idx == CFG_TEMP_CEILING) begin
                r_ceil <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_cmd_valid) begin
            r_cmd <= i_cmd;
        end
    end

    // entry memory: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_waddr] <= w_wdata;
        end
        r_rdata <= mem[w_raddr];
    end

endmodule

// ===== tb/tb_weekly_alarm_schedule_table.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_weekly_alarm_schedule_table
// Self-checking bench for the weekly alarm table. A scoreboard class keeps its
// own copy of the entry table, fire stamps and temperature limits. It predicts
// the status, fired and done results of each accepted transaction. Directed
// commands and ticks come first, then random phases under several limit
// settings, a full table with the receiver held off, and a small table at
// one time of day driven by id.
// ----------------------------------------------------------------------------
module tb_weekly_alarm_schedule_table;
    import weas_pkg::*;

    localparam int          CLK_HALF       = 5;
    localparam int          RESET_CYCLES   = 9;
    localparam int          DRAIN_CYCLES   = 64;
    localparam int          RX_HOLD_CYCLES = 400;
    localparam int unsigned MAX_CYCLES     = 5_000_000;
    localparam logic [2:0]  OP_RSVD6       = 3'd6;
    localparam logic [2:0]  OP_RSVD7       = 3'd7;

    class alarm_table_sb;
        t_entry      slots [TABLE_DEPTH];
        logic [31:0] stamp_at [TABLE_DEPTH];
        bit          stamp_vld [TABLE_DEPTH];
        int          count;
        logic [15:0] id_next;
        logic [7:0]  temp_lo;
        logic [7:0]  temp_hi;
        t_result     pending_results [$];
        int unsigned n_err;
        int unsigned n_seen;
        int unsigned n_fired;

        function new();
            count   = 0;
            id_next = ID_FIRST;
            temp_lo = TEMP_FLOOR_RST;
            temp_hi = TEMP_CEILING_RST;
            n_err   = 0;
            n_seen  = 0;
            n_fired = 0;
        endfunction

        function void set_limit(logic [CFG_IDX_W-1:0] idx, logic [7:0] v);
            if (idx == CFG_TEMP_FLOOR)
                temp_lo = v;
            else
                temp_hi = v;
        endfunction

        function int pending();
            return pending_results.size();
        endfunction

        // first entry in table order wins when ids repeat
        function int find(logic [15:0] id);
            for (int i = 0; i < count; i++)
                if (slots[i].id == id)
                    return i;
            return -1;
        endfunction

        function void push(logic [1:0] kind, logic [1:0] st, logic [15:0] id,
                           logic [3:0] act, logic [7:0] val, logic lst);
            t_result r;
            r.kind   = kind;
            r.status = st;
            r.id     = id;
            r.action = act;
            r.value  = val;
            r.last   = lst;
            pending_results.push_back(r);
        endfunction

        function void load(int idx, t_cmd c);
            slots[idx].enabled = c.entry_enabled;
            slots[idx].days    = c.entry_days;
            slots[idx].hour    = c.entry_hour;
            slots[idx].minute  = c.entry_minute;
            slots[idx].action  = c.entry_action;
            slots[idx].value   = c.entry_value;
            stamp_vld[idx]     = 1'b0;
            stamp_at[idx]      = '0;
        endfunction

        function void take_command(t_cmd c);
            int         idx;
            logic [6:0] wmask;
            logic [7:0] val;
            case (c.opcode)
                OP_TICK: begin
                    wmask = (c.now_weekday == WDAY_NONE) ? 7'd0 : (7'd1 << c.now_weekday);
                    for (int i = 0; i < count; i++) begin
                        if (slots[i].enabled && (slots[i].days & wmask) != 7'd0 &&
                            slots[i].hour == c.now_hour && slots[i].minute == c.now_minute &&
                            !(stamp_vld[i] && stamp_at[i] == c.now_stamp)) begin
                            val = 8'd0;
                            // raise to the floor first, so the ceiling wins
                            if (slots[i].action == ACT_SET_TEMP) begin
                                val = slots[i].value;
                                if (val < temp_lo)
                                    val = temp_lo;
                                if (val > temp_hi)
                                    val = temp_hi;
                            end
                            push(KIND_FIRED, ST_OK, slots[i].id, slots[i].action, val, 1'b0);
                            stamp_at[i]  = c.now_stamp;
                            stamp_vld[i] = 1'b1;
                            n_fired++;
                        end
                    end
                    push(KIND_DONE, ST_OK, 16'd0, 4'd0, 8'd0, 1'b1);
                end
                OP_ADD: begin
                    if (count >= TABLE_DEPTH) begin
                        push(KIND_STATUS, ST_FULL, 16'd0, 4'd0, 8'd0, 1'b1);
                    end else begin
                        load(count, c);
                        slots[count].id = id_next;
                        count++;
                        push(KIND_STATUS, ST_OK, id_next, 4'd0, 8'd0, 1'b1);
                        id_next = id_next + 16'd1;
                    end
                end
                OP_UPDATE, OP_REMOVE, OP_ENABLE: begin
                    idx = find(c.entry_id);
                    if (idx < 0) begin
                        push(KIND_STATUS, ST_NOT_FOUND, 16'd0, 4'd0, 8'd0, 1'b1);
                    end else begin
                        if (c.opcode == OP_UPDATE) begin
                            load(idx, c);
                        end else if (c.opcode == OP_ENABLE) begin
                            slots[idx].enabled = c.entry_enabled;
                        end else begin
                            // compact: move everything behind the hole up one place
                            for (int i = idx; i + 1 < count; i++) begin
                                slots[i]     = slots[i + 1];
                                stamp_at[i]  = stamp_at[i + 1];
                                stamp_vld[i] = stamp_vld[i + 1];
                            end
                            count--;
                        end
                        push(KIND_STATUS, ST_OK, 16'd0, 4'd0, 8'd0, 1'b1);
                    end
                end
                OP_CLEAR: begin
                    count   = 0;
                    id_next = ID_FIRST;
                    push(KIND_STATUS, ST_OK, 16'd0, 4'd0, 8'd0, 1'b1);
                end
                default: ;
            endcase
        endfunction

        function void flag(string why, t_result want, t_result got);
            if (n_err < 10) begin
                $display("MISMATCH (%s) at %0t", why, $realtime);
                $display("    expected kind=%0d st=%0d id=%0d act=%0d val=%0d last=%0d",
                         want.kind, want.status, want.id, want.action,
                         want.value, want.last);
                $display("    got      kind=%0d st=%0d id=%0d act=%0d val=%0d last=%0d",
                         got.kind, got.status, got.id, got.action, got.value, got.last);
            end
            n_err++;
        endfunction

        function void check_result(t_result got);
            t_result want;
            n_seen++;
            if (pending_results.size() == 0) begin
                flag("unexpected result", '0, got);
                return;
            end
            want = pending_results.pop_front();
            if (got.kind !== want.kind || got.status !== want.status ||
                got.id !== want.id || got.action !== want.action ||
                got.value !== want.value || got.last !== want.last)
                flag("field mismatch", want, got);
        endfunction
    endclass

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    logic [IN_TUSER_W-1:0]  s_axis_tuser;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic [OUT_TUSER_W-1:0] m_axis_tuser;
    logic                   m_axis_tlast;
    logic                   i_cfg_we;
    logic [CFG_IDX_W-1:0]   i_cfg_idx;
    logic [CFG_W-1:0]       i_cfg_data;

    alarm_table_sb sb;
    t_result       seen_res;
    bit            src_gaps;
    bit            rx_gaps;
    bit            rx_hold_req;
    logic [31:0]   stamp_now;
    int unsigned   cycle_cnt;
    int unsigned   n_items;

    weekly_alarm_schedule_table dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    // result monitor: tdata = status, id_out, fired_action, fired_value
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            seen_res.kind   = m_axis_tuser;
            seen_res.status = m_axis_tdata[1:0];
            seen_res.id     = m_axis_tdata[17:2];
            seen_res.action = m_axis_tdata[21:18];
            seen_res.value  = m_axis_tdata[29:22];
            seen_res.last   = m_axis_tlast;
            sb.check_result(seen_res);
        end
    end

    // receiver: random stalls, plus one long hold-off on request
    initial begin
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge i_clk);
                m_axis_tready <= 1'b1;
            end else if (rx_gaps && $urandom_range(0, 5) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge i_clk);
                m_axis_tready <= 1'b1;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    initial begin
        cycle_cnt = 0;
        while (cycle_cnt < MAX_CYCLES) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("Timeout after %0d cycles, %0d results still due", cycle_cnt, sb.pending());
        $display("Test completed with failures");
        $finish;
    end

    task automatic send_item(input t_cmd c);
        if (src_gaps && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= c.opcode;
        s_axis_tdata  <= {3'b000, c.now_stamp, c.now_minute, c.now_hour, c.now_weekday,
                          c.entry_value, c.entry_action, c.entry_minute, c.entry_hour,
                          c.entry_days, c.entry_enabled, c.entry_id};
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        sb.take_command(c);
        n_items++;
    endtask

    // stop offering and wait until every predicted result has come back
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_temp_limits(input logic [7:0] lo, input logic [7:0] hi);
        drain();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_TEMP_FLOOR;
        i_cfg_data <= lo;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_TEMP_CEILING;
        i_cfg_data <= hi;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        sb.set_limit(CFG_TEMP_FLOOR, lo);
        sb.set_limit(CFG_TEMP_CEILING, hi);
    endtask

    function automatic t_cmd noise_cmd();
        logic [127:0] raw;
        raw = {$urandom(), $urandom(), $urandom(), $urandom()};
        return raw[$bits(t_cmd)-1:0];
    endfunction

    function automatic t_cmd entry_cmd(logic [2:0] op, logic [15:0] id, logic en,
                                       logic [6:0] days, logic [4:0] hr, logic [5:0] mn,
                                       logic [3:0] act, logic [7:0] val);
        t_cmd c;
        c               = noise_cmd();
        c.opcode        = op;
        c.entry_id      = id;
        c.entry_enabled = en;
        c.entry_days    = days;
        c.entry_hour    = hr;
        c.entry_minute  = mn;
        c.entry_action  = act;
        c.entry_value   = val;
        return c;
    endfunction

    function automatic t_cmd tick_cmd(logic [2:0] wd, logic [4:0] hr, logic [5:0] mn,
                                      logic [31:0] stamp);
        t_cmd c;
        c             = noise_cmd();
        c.opcode      = OP_TICK;
        c.now_weekday = wd;
        c.now_hour    = hr;
        c.now_minute  = mn;
        c.now_stamp   = stamp;
        return c;
    endfunction

    // few distinct times, so ticks keep hitting stored entries
    function automatic logic [4:0] pool_hour();
        case ($urandom_range(0, 3))
            0: return 5'd7;
            1: return 5'd12;
            2: return 5'd23;
            default: return 5'($urandom_range(0, 31));
        endcase
    endfunction

    function automatic logic [5:0] pool_minute();
        case ($urandom_range(0, 3))
            0: return 6'd0;
            1: return 6'd30;
            2: return 6'd59;
            default: return 6'($urandom_range(0, 63));
        endcase
    endfunction

    function automatic t_cmd rand_cmd();
        t_cmd        c;
        int unsigned pick;
        c    = noise_cmd();
        pick = $urandom_range(0, 99);
        if (pick < 6)
            return c;
        c.entry_hour    = pool_hour();
        c.entry_minute  = pool_minute();
        c.now_hour      = pool_hour();
        c.now_minute    = pool_minute();
        c.entry_enabled = ($urandom_range(0, 4) != 0);
        if ($urandom_range(0, 3) == 0)
            c.entry_action = ACT_SET_TEMP;
        if (sb.count > 0 && $urandom_range(0, 5) != 0)
            c.entry_id = sb.slots[$urandom_range(0, sb.count - 1)].id;
        if ($urandom_range(0, 9) != 0)
            c.now_weekday = 3'($urandom_range(0, 6));
        // repeat the stamp now and then to check the once-per-minute rule
        if ($urandom_range(0, 3) != 0)
            stamp_now = stamp_now + 32'd1;
        c.now_stamp = stamp_now;
        if (pick < 45)
            c.opcode = OP_TICK;
        else if (pick < 70)
            c.opcode = OP_ADD;
        else if (pick < 80)
            c.opcode = OP_UPDATE;
        else if (pick < 88)
            c.opcode = OP_REMOVE;
        else if (pick < 96)
            c.opcode = OP_ENABLE;
        else if (pick < 98)
            c.opcode = OP_CLEAR;
        else
            c.opcode = ($urandom_range(0, 1) != 0) ? OP_RSVD6 : OP_RSVD7;
        return c;
    endfunction

    task automatic run_random(input int unsigned n);
        t_cmd        c;
        int unsigned done_cnt;
        done_cnt = 0;
        while (done_cnt < n) begin
            c = rand_cmd();
            send_item(c);
            if (c.opcode <= OP_CLEAR)
                done_cnt++;
        end
    endtask

    initial begin
        sb            = new();
        src_gaps      = 1'b1;
        rx_gaps       = 1'b1;
        rx_hold_req   = 1'b0;
        stamp_now     = 32'd1000;
        n_items       = 0;
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= '0;
        i_cfg_we      <= 1'b0;
        i_cfg_idx     <= '0;
        i_cfg_data    <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part, reset limits 20..40
        send_item(tick_cmd(3'd0, 5'd23, 6'd59, 32'd5));
        send_item(entry_cmd(OP_REMOVE, 16'd5, 1'b0, 7'h00, 5'd0, 6'd0, 4'd0, 8'd0));
        send_item(entry_cmd(OP_ADD, 16'hFFFF, 1'b1, 7'h7F, 5'd23, 6'd59, ACT_SET_TEMP, 8'd0));
        send_item(entry_cmd(OP_ADD, 16'h0, 1'b1, 7'h01, 5'd23, 6'd59, ACT_SET_TEMP, 8'd255));
        send_item(entry_cmd(OP_ADD, 16'h0, 1'b1, 7'h00, 5'd23, 6'd59, 4'd0, 8'd77));
        send_item(entry_cmd(OP_ADD, 16'h0, 1'b0, 7'h7F, 5'd23, 6'd59, 4'd15, 8'd255));
        send_item(entry_cmd(OP_ADD, 16'h0, 1'b1, 7'h7F, 5'd0, 6'd0, 4'd9, 8'hAA));
        send_item(entry_cmd(OP_ADD, 16'h0, 1'b1, 7'h40, 5'd23, 6'd59, ACT_SET_TEMP, 8'd30));
        send_item(tick_cmd(3'd0, 5'd23, 6'd59, 32'd100));
        send_item(tick_cmd(3'd0, 5'd23, 6'd59, 32'd100));
        send_item(tick_cmd(WDAY_NONE, 5'd23, 6'd59, 32'd101));
        send_item(tick_cmd(3'd6, 5'd23, 6'd59, 32'd102));
        send_item(entry_cmd(OP_ENABLE, 16'd4, 1'b1, 7'h00, 5'd0, 6'd0, 4'd0, 8'd0));
        send_item(tick_cmd(3'd6, 5'd23, 6'd59, 32'd103));
        send_item(tick_cmd(3'd3, 5'd0, 6'd0, 32'd0));
        send_item(entry_cmd(OP_UPDATE, 16'd1, 1'b1, 7'h7F, 5'd0, 6'd0, 4'd7, 8'd1));
        send_item(tick_cmd(3'd3, 5'd0, 6'd0, 32'd0));
        send_item(entry_cmd(OP_UPDATE, 16'd999, 1'b1, 7'h7F, 5'd1, 6'd1, 4'd1, 8'd1));
        send_item(entry_cmd(OP_ENABLE, 16'd999, 1'b0, 7'h00, 5'd0, 6'd0, 4'd0, 8'd0));
        send_item(entry_cmd(OP_REMOVE, 16'd2, 1'b0, 7'h00, 5'd0, 6'd0, 4'd0, 8'd0));
        send_item(entry_cmd(OP_RSVD6, 16'd3, 1'b1, 7'h7F, 5'd0, 6'd0, 4'd0, 8'd0));
        send_item(entry_cmd(OP_RSVD7, 16'd3, 1'b1, 7'h7F, 5'd0, 6'd0, 4'd0, 8'd0));
        send_item(tick_cmd(3'd6, 5'd23, 6'd59, 32'hFFFF_FFFF));
        send_item(entry_cmd(OP_REMOVE, 16'd6, 1'b0, 7'h00, 5'd0, 6'd0, 4'd0, 8'd0));
        send_item(entry_cmd(OP_CLEAR, 16'd0, 1'b0, 7'h00, 5'd0, 6'd0, 4'd0, 8'd0));

        set_temp_limits(8'd0, 8'd255);
        run_random(80);

        // floor above ceiling; fill the table, then hold the receiver off
        // while full-table ticks pile up behind the output
        set_temp_limits(8'd200, 8'd100);
        send_item(entry_cmd(OP_CLEAR, 16'd0, 1'b0, 7'h00, 5'd0, 6'd0, 4'd0, 8'd0));
        for (int k = 0; k < TABLE_DEPTH + 2; k++)
            send_item(entry_cmd(OP_ADD, 16'd0, 1'b1, 7'h7F, 5'd7, 6'd30, 4'(k), 8'($urandom)));
        rx_hold_req = 1'b1;
        for (int k = 0; k < 4; k++) begin
            stamp_now = stamp_now + 32'd1;
            send_item(tick_cmd(3'($urandom_range(0, 6)), 5'd7, 6'd30, stamp_now));
        end
        drain();
        send_item(tick_cmd(3'($urandom_range(0, 6)), 5'd7, 6'd30, stamp_now));

        set_temp_limits(8'd255, 8'd0);
        run_random(70);

        // small table at noon, driven by id
        set_temp_limits(8'd25, 8'd35);
        src_gaps = 1'b0;
        rx_gaps  = 1'b0;
        send_item(entry_cmd(OP_CLEAR, 16'd0, 1'b0, 7'h00, 5'd0, 6'd0, 4'd0, 8'd0));
        send_item(entry_cmd(OP_ADD, 16'd0, 1'b1, 7'h7F, 5'd12, 6'd0, ACT_SET_TEMP, 8'd30));
        send_item(entry_cmd(OP_ADD, 16'd0, 1'b1, 7'h7F, 5'd12, 6'd0, 4'd3, 8'd0));
        send_item(entry_cmd(OP_ADD, 16'd0, 1'b1, 7'h7F, 5'd12, 6'd0, ACT_SET_TEMP, 8'd10));
        send_item(entry_cmd(OP_ADD, 16'd0, 1'b1, 7'h04, 5'd12, 6'd0, ACT_SET_TEMP, 8'd99));
        send_item(tick_cmd(3'd2, 5'd12, 6'd0, 32'd7));
        send_item(entry_cmd(OP_ENABLE, 16'd1, 1'b0, 7'h00, 5'd0, 6'd0, 4'd0, 8'd0));
        send_item(tick_cmd(3'd2, 5'd12, 6'd0, 32'd8));
        send_item(entry_cmd(OP_REMOVE, 16'd1, 1'b0, 7'h00, 5'd0, 6'd0, 4'd0, 8'd0));
        send_item(entry_cmd(OP_UPDATE, 16'd1, 1'b1, 7'h7F, 5'd12, 6'd0, 4'd5, 8'd0));
        send_item(tick_cmd(3'd2, 5'd12, 6'd0, 32'd8));

        // last stretch: no idling on either side
        run_random(55);
        drain();

        $display("Sent %0d transactions, checked %0d results", n_items, sb.n_seen);
        $display("Covered %0d fired entries across five limit settings, mismatches: %0d",
                 sb.n_fired, sb.n_err);
        if (sb.n_err == 0 && sb.pending() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/weas_pkg.sv
rtl/weas_out.sv
rtl/weas_engine.sv
rtl/weekly_alarm_schedule_table.sv
tb/tb_weekly_alarm_schedule_table.sv
